// File: sv/bdf1_pkg.sv
// Shared types, constants and the microcode table of the biquad filter.
package bdf1_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC_BITS = 15;
   localparam int ACC_BITS       = 32;
   localparam int LEVEL_BITS     = 8;
   localparam int LEVEL_SHIFT    = 8;
   localparam int PROD_BITS      = COEF_BITS + ACC_BITS;
   localparam int SCALED_BITS    = PROD_BITS - LEVEL_SHIFT;
   localparam int CSR_INDEX_BITS = 3;
   localparam int STEP_BITS      = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_LEVEL = 3'd5;

   localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET   = 18'sd32767;
   localparam logic [LEVEL_BITS-1:0]       OUT_LEVEL_RESET = 8'd255;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_TAKE   = 3'd0;
   localparam step_type STEP_MUL_B1 = 3'd1;
   localparam step_type STEP_MUL_B2 = 3'd2;
   localparam step_type STEP_MUL_A1 = 3'd3;
   localparam step_type STEP_MUL_A2 = 3'd4;
   localparam step_type STEP_LAST   = 3'd5;
   localparam step_type STEP_LEVEL  = 3'd6;
   localparam step_type STEP_OUTPUT = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          frame_end_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
      logic                          frame_end_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
      logic [LEVEL_BITS-1:0]       level;
   } coef_type;

   typedef enum logic [2:0] {
      MUL_A_B0,
      MUL_A_B1,
      MUL_A_B2,
      MUL_A_A1,
      MUL_A_A2,
      MUL_A_LEVEL
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MUL_B_REQ,
      MUL_B_X1,
      MUL_B_X2,
      MUL_B_Y1,
      MUL_B_Y2,
      MUL_B_ACC
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      acc_op_type    acc_op;
      logic          hist_upd;
      cond_type      cond;
      step_type      target;
   } ucode_type;

   typedef struct packed {
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      acc_op_type    acc_op;
      logic          hist_upd;
      logic          take_in;
      logic          out_load;
   } ctrl_type;

   function automatic ucode_type micro_word(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_TAKE:   w = '{MUL_A_B0,    MUL_B_REQ, ACC_CLEAR, 1'b0, COND_REQ,      STEP_MUL_B1};
         STEP_MUL_B1: w = '{MUL_A_B1,    MUL_B_X1,  ACC_ADD,   1'b0, COND_ALWAYS,   STEP_MUL_B2};
         STEP_MUL_B2: w = '{MUL_A_B2,    MUL_B_X2,  ACC_ADD,   1'b0, COND_ALWAYS,   STEP_MUL_A1};
         STEP_MUL_A1: w = '{MUL_A_A1,    MUL_B_Y1,  ACC_ADD,   1'b0, COND_ALWAYS,   STEP_MUL_A2};
         STEP_MUL_A2: w = '{MUL_A_A2,    MUL_B_Y2,  ACC_SUB,   1'b0, COND_ALWAYS,   STEP_LAST};
         STEP_LAST:   w = '{MUL_A_LEVEL, MUL_B_ACC, ACC_SUB,   1'b0, COND_ALWAYS,   STEP_LEVEL};
         STEP_LEVEL:  w = '{MUL_A_LEVEL, MUL_B_ACC, ACC_HOLD,  1'b1, COND_ALWAYS,   STEP_OUTPUT};
         STEP_OUTPUT: w = '{MUL_A_LEVEL, MUL_B_ACC, ACC_HOLD,  1'b0, COND_RSP_FREE, STEP_TAKE};
      endcase
      return w;
   endfunction

endpackage

// File: sv/biquad_df1_filter_q15.sv
// Top level of the direct form 1 biquad filter with Q15 coefficients.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   req_payload (sample_in, frame_end_in)
//   rsp_     out        rsp_valid/rsp_stall   rsp_payload (sample_out, clipped, frame_end_out)
//   csr_     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// For each item the microcode steps the one shared 18x32 multiplier
// through five taps and the level gain, then loads the output register.
// A new item is taken while the previous result still waits in the output register.
// A stalled result holds the sequencer on its output step until the transfer.
// Synchronous reset clears the history and loads the reset coefficients.
module biquad_df1_filter_q15
   import bdf1_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata
);

   coef_type coef;
   ctrl_type ctrl;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   bdf1_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   bdf1_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   bdf1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .coef        (coef),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   always_comb begin
      priority if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_transfer_per_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input transfer taken on two cycles in a row");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a stalled result waits");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.out_load))
      else $error("result valid rose without a result load");

endmodule

// File: sv/bdf1_csr.sv
// Coefficient and output level registers written through the configuration port.
module bdf1_csr
   import bdf1_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata,
   output coef_type                  coef
);

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF_B0:   coef_in.b0    = csr_wdata;
            CSR_COEF_B1:   coef_in.b1    = csr_wdata;
            CSR_COEF_B2:   coef_in.b2    = csr_wdata;
            CSR_COEF_A1:   coef_in.a1    = csr_wdata;
            CSR_COEF_A2:   coef_in.a2    = csr_wdata;
            CSR_OUT_LEVEL: coef_in.level = csr_wdata[LEVEL_BITS-1:0];
            default:       coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0    <= COEF_B0_RESET;
         coef_ff.b1    <= '0;
         coef_ff.b2    <= '0;
         coef_ff.a1    <= '0;
         coef_ff.a2    <= '0;
         coef_ff.level <= OUT_LEVEL_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// File: sv/bdf1_sequencer.sv
// Step counter and microcode table that issue one control word per cycle.
module bdf1_sequencer
   import bdf1_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     rsp_free,
   output ctrl_type ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      go;

   assign word      = micro_word(step_ff);
   assign req_stall = (word.cond != COND_REQ);

   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:   go = 1'b1;
         COND_REQ:      go = req_valid;
         COND_RSP_FREE: go = rsp_free;
         default:       go = 1'b0;
      endcase
      step_in = go ? word.target : step_ff;
   end

   always_comb begin
      ctrl.mul_a    = word.mul_a;
      ctrl.mul_b    = word.mul_b;
      ctrl.acc_op   = word.acc_op;
      ctrl.hist_upd = word.hist_upd;
      ctrl.take_in  = (word.cond == COND_REQ) && go;
      ctrl.out_load = (word.cond == COND_RSP_FREE) && go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_TAKE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: sv/bdf1_datapath.sv
// Shared multiplier, wrapping accumulator, filter history and output saturation.
module bdf1_datapath
   import bdf1_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_type        ctrl,
   input  coef_type        coef,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   localparam logic signed [SCALED_BITS-1:0] SAT_MAX =
      SCALED_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [SCALED_BITS-1:0] SAT_MIN = -SAT_MAX - 1;

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          fe_ff;
   logic signed [SAMPLE_BITS-1:0] x1_ff;
   logic signed [SAMPLE_BITS-1:0] x2_ff;
   logic signed [ACC_BITS-1:0]    y1_ff;
   logic signed [ACC_BITS-1:0]    y2_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [COEF_BITS-1:0]   mul_a;
   logic signed [ACC_BITS-1:0]    mul_b;
   logic signed [ACC_BITS-1:0]    term;
   logic signed [SCALED_BITS-1:0] scaled;
   rsp_payload_type               rsp_in;
   rsp_payload_type               rsp_ff;

   assign term        = prod_ff[COEF_FRAC_BITS+ACC_BITS-1:COEF_FRAC_BITS];
   assign scaled      = prod_ff[PROD_BITS-1:LEVEL_SHIFT];
   assign rsp_payload = rsp_ff;

   always_comb begin
      unique case (ctrl.mul_a)
         MUL_A_B0:    mul_a = coef.b0;
         MUL_A_B1:    mul_a = coef.b1;
         MUL_A_B2:    mul_a = coef.b2;
         MUL_A_A1:    mul_a = coef.a1;
         MUL_A_A2:    mul_a = coef.a2;
         MUL_A_LEVEL: mul_a = {{(COEF_BITS-LEVEL_BITS){1'b0}}, coef.level};
         default:     mul_a = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.mul_b)
         MUL_B_REQ: mul_b = {{(ACC_BITS-SAMPLE_BITS){req_payload.sample_in[SAMPLE_BITS-1]}},
                             req_payload.sample_in};
         MUL_B_X1:  mul_b = {{(ACC_BITS-SAMPLE_BITS){x1_ff[SAMPLE_BITS-1]}}, x1_ff};
         MUL_B_X2:  mul_b = {{(ACC_BITS-SAMPLE_BITS){x2_ff[SAMPLE_BITS-1]}}, x2_ff};
         MUL_B_Y1:  mul_b = y1_ff;
         MUL_B_Y2:  mul_b = y2_ff;
         MUL_B_ACC: mul_b = acc_ff;
         default:   mul_b = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + term;
         ACC_SUB:   acc_in = acc_ff - term;
         default:   acc_in = acc_ff;
      endcase
   end

   // Saturation counts reaching a limit exactly as a clip.
   always_comb begin
      rsp_in.frame_end_out = fe_ff;
      priority if (scaled >= SAT_MAX) begin
         rsp_in.sample_out = SAT_MAX[SAMPLE_BITS-1:0];
         rsp_in.clipped    = 1'b1;
      end else if (scaled <= SAT_MIN) begin
         rsp_in.sample_out = SAT_MIN[SAMPLE_BITS-1:0];
         rsp_in.clipped    = 1'b1;
      end else begin
         rsp_in.sample_out = scaled[SAMPLE_BITS-1:0];
         rsp_in.clipped    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (ctrl.take_in) begin
         x_ff  <= req_payload.sample_in;
         fe_ff <= req_payload.frame_end_in;
      end
      if (ctrl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (ctrl.hist_upd) begin
         x1_ff <= x_ff;
         x2_ff <= x1_ff;
         y1_ff <= acc_ff;
         y2_ff <= y1_ff;
      end
   end

endmodule
